/* rtl/ipv4fhf_pkg.sv */
package ipv4fhf_pkg;

    typedef enum logic [2:0] {
        REASON_PASS      = 3'd0,
        REASON_NON_IPV4  = 3'd1,
        REASON_MALFORMED = 3'd2,
        REASON_FRAGMENT  = 3'd3,
        REASON_TCP_FLAGS = 3'd4
    } reason_t;

    localparam int unsigned LEN_W  = 14;
    localparam int unsigned DATA_W = 88;

    // configuration register indexes
    localparam logic CFG_DROP_FRAGMENTS  = 1'b0;
    localparam logic CFG_CHECK_TCP_FLAGS = 1'b1;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_8021Q  = 16'h8100;
    localparam logic [15:0] ETYPE_8021AD = 16'h88A8;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [5:0] ETH_HDR_LEN  = 6'd14;
    localparam logic [5:0] VLAN_HDR_LEN = 6'd18;

    localparam logic [12:0] FRAG_OFFSET_MASK = 13'h1FFF;

    // TCP flag bits
    localparam logic [7:0] TCP_FIN = 8'h01;
    localparam logic [7:0] TCP_SYN = 8'h02;
    localparam logic [7:0] TCP_RST = 8'h04;
    localparam logic [7:0] TCP_PSH = 8'h08;
    localparam logic [7:0] TCP_URG = 8'h20;

    function automatic logic tcp_flags_bad(input logic [7:0] f);
        logic [7:0] syn_fin;
        logic [7:0] syn_rst;
        logic [7:0] fin_rst;
        logic [7:0] xmas;
        syn_fin = TCP_SYN | TCP_FIN;
        syn_rst = TCP_SYN | TCP_RST;
        fin_rst = TCP_FIN | TCP_RST;
        xmas    = TCP_FIN | TCP_PSH | TCP_URG;
        return (f == 8'd0)
            || ((f & syn_fin) == syn_fin)
            || ((f & syn_rst) == syn_rst)
            || ((f & fin_rst) == fin_rst)
            || ((f & xmas) == xmas);
    endfunction

endpackage

/* rtl/ipv4_frame_header_filter.sv */
// Channel  | Dir | Content
// ---------+-----+-------------------------------------------------------------
// s_*      | in  | one frame byte per item, tlast on the final byte
// m_*      | out | one verdict item per frame, sent for the item carrying tlast
// cfg_*    | in  | index 0 drop_fragments, index 1 check_tcp_flags
//
// One byte is taken every cycle while s_tready is high; each byte sits in the input
// register, where its header capture and the frame verdict are computed.
// The verdict is registered into m_tdata when the last byte leaves the input register.
// A stalled verdict holds s_tready low only once a further last byte is
// waiting in the input register. rst_n clears the per-frame state, the
// pipeline valids and the configuration to their defaults.
module ipv4_frame_header_filter #(
    parameter int unsigned MAX_FRAME_BYTES = 16383
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: frame_byte[7:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    // tdata: verdict[0], reason[3:1], source_address[35:4],
    //        protocol_number[43:36], destination_port[59:44],
    //        flag_bits[67:60], frame_length[81:68], zero[87:82]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ipv4fhf_pkg::DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic                            cfg_data
);
    import ipv4fhf_pkg::*;

    localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);

    logic drop_frag_reg;
    logic check_flags_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [PW-1:0] pos_reg,   pos_next;
    logic [15:0]   etype_reg, etype_next;
    logic          tag_reg,   tag_next;
    logic [7:0]    vihl_reg,  vihl_next;
    logic [15:0]   tot_reg,   tot_next;
    logic [7:0]    ttl_reg,   ttl_next;
    logic [15:0]   frag_reg,  frag_next;
    logic [7:0]    proto_reg, proto_next;
    logic [31:0]   src_reg,   src_next;
    logic [15:0]   port_reg,  port_next;
    logic [7:0]    flags_reg, flags_next;
    logic [3:0]    off_reg,   off_next;
    logic [15:0]   ulen_reg,  ulen_next;

    logic [PW-1:0] cap_pos;
    logic [15:0]   cap_etype;
    logic          cap_tag;
    logic [7:0]    cap_vihl;
    logic [15:0]   cap_tot;
    logic [7:0]    cap_ttl;
    logic [15:0]   cap_frag;
    logic [7:0]    cap_proto;
    logic [31:0]   cap_src;
    logic [15:0]   cap_port;
    logic [7:0]    cap_flags;
    logic [3:0]    cap_off;
    logic [15:0]   cap_ulen;

    logic [5:0]    l3;
    logic [6:0]    l4;
    logic [PW-1:0] l3_pos;
    logic [PW-1:0] l4_pos;
    logic [3:0]    ihl;
    logic [7:0]    b;

    logic [PW-1:0] j_l3_pos;
    logic [PW-1:0] j_l4_pos;
    logic [3:0]    j_ihl;
    logic          res_verdict;
    reason_t       res_reason;
    logic [15:0]   res_port;
    logic [7:0]    res_flags;
    logic          res_ipv4;
    logic [LEN_W+PW-1:0] len_ext;
    logic [DATA_W-1:0]   res_data;

    logic out_free;
    logic advance;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_data_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_frag_reg   <= 1'b0;
            check_flags_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DROP_FRAGMENTS:  drop_frag_reg   <= cfg_data;
                CFG_CHECK_TCP_FLAGS: check_flags_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // header capture for the byte in the input register
    always_comb
    begin
        b      = in_byte_reg;
        ihl    = vihl_reg[3:0];
        l3     = tag_reg ? VLAN_HDR_LEN : ETH_HDR_LEN;
        l4     = {1'b0, l3} + {1'b0, ihl, 2'b00};
        l3_pos = PW'(l3);
        l4_pos = PW'(l4);

        cap_etype = etype_reg;
        cap_tag   = tag_reg;
        cap_vihl  = vihl_reg;
        cap_tot   = tot_reg;
        cap_ttl   = ttl_reg;
        cap_frag  = frag_reg;
        cap_proto = proto_reg;
        cap_src   = src_reg;
        cap_port  = port_reg;
        cap_flags = flags_reg;
        cap_off   = off_reg;
        cap_ulen  = ulen_reg;

        if (pos_reg == PW'(12))
            cap_etype[15:8] = b;
        if (pos_reg == PW'(13))
        begin
            cap_etype[7:0] = b;
            if (({etype_reg[15:8], b} == ETYPE_8021Q) || ({etype_reg[15:8], b} == ETYPE_8021AD))
                cap_tag = 1'b1;
        end
        // inner type after the tag
        if (tag_reg && pos_reg == PW'(16))
            cap_etype[15:8] = b;
        if (tag_reg && pos_reg == PW'(17))
            cap_etype[7:0] = b;

        if (pos_reg == l3_pos)
            cap_vihl = b;
        if (pos_reg == l3_pos + PW'(2))
            cap_tot[15:8] = b;
        if (pos_reg == l3_pos + PW'(3))
            cap_tot[7:0] = b;
        if (pos_reg == l3_pos + PW'(6))
            cap_frag[15:8] = b;
        if (pos_reg == l3_pos + PW'(7))
            cap_frag[7:0] = b;
        if (pos_reg == l3_pos + PW'(8))
            cap_ttl = b;
        if (pos_reg == l3_pos + PW'(9))
            cap_proto = b;
        if ((pos_reg >= l3_pos + PW'(12)) && (pos_reg <= l3_pos + PW'(15)))
            cap_src = {src_reg[23:0], b};

        if (ihl >= 4'd5)
        begin
            if (pos_reg == l4_pos + PW'(2))
                cap_port[15:8] = b;
            if (pos_reg == l4_pos + PW'(3))
                cap_port[7:0] = b;
            if (pos_reg == l4_pos + PW'(4))
                cap_ulen[15:8] = b;
            if (pos_reg == l4_pos + PW'(5))
                cap_ulen[7:0] = b;
            if (pos_reg == l4_pos + PW'(12))
                cap_off = b[7:4];
            if (pos_reg == l4_pos + PW'(13))
                cap_flags = b;
        end

        // saturate the byte count
        if (pos_reg < PW'(MAX_FRAME_BYTES))
            cap_pos = pos_reg + PW'(1);
        else
            cap_pos = pos_reg;
    end

    // frame verdict from the captured fields, including the last byte
    always_comb
    begin
        j_ihl    = cap_vihl[3:0];
        j_l3_pos = PW'(cap_tag ? VLAN_HDR_LEN : ETH_HDR_LEN);
        j_l4_pos = j_l3_pos + PW'({j_ihl, 2'b00});

        res_verdict = 1'b1;
        res_reason  = REASON_MALFORMED;
        res_port    = 16'd0;
        res_flags   = 8'd0;
        res_ipv4    = 1'b0;

        if (cap_pos < PW'(ETH_HDR_LEN))
            res_ipv4 = 1'b0;
        else if (cap_tag && cap_pos < PW'(VLAN_HDR_LEN))
            res_ipv4 = 1'b0;
        else if (cap_etype != ETYPE_IPV4)
        begin
            res_verdict = 1'b0;
            res_reason  = REASON_NON_IPV4;
        end
        else
        begin
            res_ipv4 = 1'b1;
            if (cap_pos < j_l3_pos + PW'(20))
                res_reason = REASON_MALFORMED;
            else if (cap_vihl[7:4] != 4'd4)
                res_reason = REASON_MALFORMED;
            else if (j_ihl < 4'd5)
                res_reason = REASON_MALFORMED;
            else if (cap_pos < j_l4_pos)
                res_reason = REASON_MALFORMED;
            else if (cap_tot < {10'd0, j_ihl, 2'b00})
                res_reason = REASON_MALFORMED;
            else if (cap_ttl == 8'd0)
                res_reason = REASON_MALFORMED;
            else if ((cap_frag[12:0] & FRAG_OFFSET_MASK) != 13'd0)
            begin
                if (drop_frag_reg)
                    res_reason = REASON_FRAGMENT;
                else
                begin
                    res_verdict = 1'b0;
                    res_reason  = REASON_PASS;
                end
            end
            else if (cap_proto == PROTO_TCP)
            begin
                res_port  = cap_port;
                res_flags = cap_flags;
                if (cap_pos < j_l4_pos + PW'(20))
                    res_reason = REASON_MALFORMED;
                else if (cap_off < 4'd5)
                    res_reason = REASON_MALFORMED;
                else if (check_flags_reg && tcp_flags_bad(cap_flags))
                    res_reason = REASON_TCP_FLAGS;
                else
                begin
                    res_verdict = 1'b0;
                    res_reason  = REASON_PASS;
                end
            end
            else if (cap_proto == PROTO_UDP)
            begin
                res_port = cap_port;
                if (cap_pos < j_l4_pos + PW'(8))
                    res_reason = REASON_MALFORMED;
                else if (cap_ulen < 16'd8)
                    res_reason = REASON_MALFORMED;
                else
                begin
                    res_verdict = 1'b0;
                    res_reason  = REASON_PASS;
                end
            end
            else if (cap_proto == PROTO_ICMP && cap_pos < j_l4_pos + PW'(4))
                res_reason = REASON_MALFORMED;
            else
            begin
                res_verdict = 1'b0;
                res_reason  = REASON_PASS;
            end
        end

        len_ext  = {{LEN_W{1'b0}}, cap_pos};
        res_data = {6'd0,
                    len_ext[LEN_W-1:0],
                    res_flags,
                    res_port,
                    res_ipv4 ? cap_proto : 8'd0,
                    res_ipv4 ? cap_src : 32'd0,
                    res_reason,
                    res_verdict};
    end

    // drop per-frame state after the last byte
    always_comb
    begin
        if (in_last_reg)
        begin
            pos_next   = '0;
            etype_next = 16'd0;
            tag_next   = 1'b0;
            vihl_next  = 8'd0;
            tot_next   = 16'd0;
            ttl_next   = 8'd0;
            frag_next  = 16'd0;
            proto_next = 8'd0;
            src_next   = 32'd0;
            port_next  = 16'd0;
            flags_next = 8'd0;
            off_next   = 4'd0;
            ulen_next  = 16'd0;
        end
        else
        begin
            pos_next   = cap_pos;
            etype_next = cap_etype;
            tag_next   = cap_tag;
            vihl_next  = cap_vihl;
            tot_next   = cap_tot;
            ttl_next   = cap_ttl;
            frag_next  = cap_frag;
            proto_next = cap_proto;
            src_next   = cap_src;
            port_next  = cap_port;
            flags_next = cap_flags;
            off_next   = cap_off;
            ulen_next  = cap_ulen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= 16'd0;
            tag_reg   <= 1'b0;
            vihl_reg  <= 8'd0;
            tot_reg   <= 16'd0;
            ttl_reg   <= 8'd0;
            frag_reg  <= 16'd0;
            proto_reg <= 8'd0;
            src_reg   <= 32'd0;
            port_reg  <= 16'd0;
            flags_reg <= 8'd0;
            off_reg   <= 4'd0;
            ulen_reg  <= 16'd0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            tag_reg   <= tag_next;
            vihl_reg  <= vihl_next;
            tot_reg   <= tot_next;
            ttl_reg   <= ttl_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            port_reg  <= port_next;
            flags_reg <= flags_next;
            off_reg   <= off_next;
            ulen_reg  <= ulen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (advance && in_last_reg)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            m_data_reg <= res_data;
    end

endmodule

/* rtl/ipv4fhf_checker.sv */
module ipv4fhf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [7:0]                      s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ipv4fhf_pkg::DATA_W-1:0]  m_tdata,
    input logic                            cfg_we,
    input logic                            cfg_index,
    input logic                            cfg_data
);
    import ipv4fhf_pkg::*;

    logic       verdict;
    logic [2:0] reason;
    logic [31:0] src;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [7:0]  flags;

    assign verdict = m_tdata[0];
    assign reason  = m_tdata[3:1];
    assign src     = m_tdata[35:4];
    assign proto   = m_tdata[43:36];
    assign port    = m_tdata[59:44];
    assign flags   = m_tdata[67:60];

    // hold a stalled verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed");

    // pass exactly for the two pass reasons
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((verdict == 1'b0) ==
                      (reason == REASON_PASS || reason == REASON_NON_IPV4)))
        else $error("verdict disagrees with reason");

    // non-IPv4 frames report no header fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && reason == REASON_NON_IPV4 |->
            src == 32'd0 && proto == 8'd0 && port == 16'd0 && flags == 8'd0)
        else $error("non-IPv4 verdict carries header fields");

    // ports only for TCP or UDP, flags only for TCP
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (port == 16'd0 || proto == PROTO_TCP || proto == PROTO_UDP)
                  && (flags == 8'd0 || proto == PROTO_TCP))
        else $error("layer 4 fields reported for wrong protocol");

endmodule

bind ipv4_frame_header_filter ipv4fhf_checker u_ipv4fhf_checker (.*);
